// File: rtl/isoac_pkg.sv
`default_nettype none
package isoac_pkg;

    // operation codes of an input item
    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_RX_OK   = 2'd1,
        OP_RX_FAIL = 2'd2
    } op_t;

    // sequence phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ATQA = 2'd1,
        PH_SDD  = 2'd2,
        PH_SAK  = 2'd3
    } phase_t;

    // result kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // finish status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PROTO   = 2'd1;
    localparam logic [1:0] ST_RX_FAIL = 2'd2;

    // frame constants
    localparam logic [7:0] WUPA_CODE    = 8'h52;
    localparam logic [7:0] TAG_BYTE     = 8'h88;
    localparam logic [7:0] SEL_BASE     = 8'h93;
    localparam logic [7:0] NVB_SDD      = 8'h20;
    localparam logic [7:0] NVB_SEL      = 8'h70;
    localparam logic [7:0] ATQA_AC_MASK = 8'h1f;

    // frame lengths
    localparam logic [2:0] LEN_WUPA = 3'd1;
    localparam logic [2:0] LEN_SDD  = 3'd2;
    localparam logic [2:0] LEN_SEL  = 3'd7;
    localparam logic [2:0] LEN_ATQA = 3'd2;
    localparam logic [2:0] LEN_UID  = 3'd5;
    localparam logic [2:0] LEN_SAK  = 3'd1;

endpackage
`default_nettype wire

// File: rtl/iso14443a_anticollision_sequencer.sv
// ISO 14443-A reader-side anticollision and select sequencer for a single card.
// A start item sends WUPA; every received frame (or receive failure) then yields
// the next frame to transmit or a finish result, one result per item at most.
// Each item passes through an input register and then the result register, and
// one item per cycle is sustained while no result is stalled; the only thing that
// holds an item back is a result still waiting behind out_stall. The ATQA, SAK,
// UID bytes and UID count outputs show the state as it stands after the item that
// produced the current result. UID_BYTES (4 to 10) sets how many UID bytes are
// kept; further bytes are dropped and the count saturates.
`default_nettype none
module iso14443a_anticollision_sequencer
    import isoac_pkg::*;
#(
    parameter int UID_BYTES = 10
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [2:0]  rx_length,
    input  wire logic [39:0] rx_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             result_kind,
    output logic [55:0]      tx_data,
    output logic [2:0]       tx_length,
    output logic             tx_short_frame,
    output logic             tx_crc_on,
    output logic [1:0]       finish_status,
    output logic [15:0]      answer_to_request,
    output logic [7:0]       select_ack,
    output logic [3:0]       uid_length,
    output logic [63:0]      uid_low,
    output logic [15:0]      uid_high
);

    // input register
    logic        s1_vld_reg, s1_vld_next;
    logic [1:0]  op_reg;
    logic [2:0]  len_reg;
    logic [39:0] rx_reg;

    // sequence state
    phase_t      phase_reg, phase_next;
    logic [1:0]  level_reg, level_next;
    logic        tag_reg, tag_next;
    logic [7:0]  uid_reg  [UID_BYTES];
    logic [7:0]  uid_next [UID_BYTES];
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] atqa_reg, atqa_next;
    logic [7:0]  sak_reg, sak_next;

    // result register
    logic        out_vld_reg;
    logic        kind_reg, kind_next;
    logic [55:0] txd_reg, txd_next;
    logic [2:0]  txl_reg, txl_next;
    logic        sf_reg, sf_next;
    logic        crc_reg, crc_next;
    logic [1:0]  st_reg, st_next;

    logic        res_hit;
    logic        advance;
    logic        in_take;
    logic [7:0]  b [5];
    logic        skip;
    logic [4:0]  cnt_sum;
    logic [7:0]  sel_code;

    // handshake: stage one moves on when its result has room
    assign advance  = s1_vld_reg && (!res_hit || !out_vld_reg || !out_stall);
    assign in_stall = s1_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (in_take)
        begin
            s1_vld_next = 1'b1;
        end
        else if (advance)
        begin
            s1_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg  <= operation;
            len_reg <= rx_length;
            rx_reg  <= rx_data;
        end
    end

    // byte split and helpers for the received frame
    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            b[i] = rx_reg[8*i +: 8];
        end
    end

    assign skip     = (b[0] == TAG_BYTE);
    assign cnt_sum  = {1'b0, cnt_reg} + (skip ? 5'd3 : 5'd4);
    assign sel_code = SEL_BASE + {5'b0, level_reg, 1'b0};

    // protocol decision for the item in stage one
    always_comb
    begin
        phase_next = phase_reg;
        level_next = level_reg;
        tag_next   = tag_reg;
        cnt_next   = cnt_reg;
        atqa_next  = atqa_reg;
        sak_next   = sak_reg;
        for (int j = 0; j < UID_BYTES; j++)
        begin
            uid_next[j] = uid_reg[j];
        end
        res_hit   = 1'b0;
        kind_next = KIND_TX;
        txd_next  = '0;
        txl_next  = '0;
        sf_next   = 1'b0;
        crc_next  = 1'b0;
        st_next   = ST_OK;

        case (op_reg)
            OP_START:
            begin
                level_next = '0;
                tag_next   = 1'b0;
                cnt_next   = '0;
                atqa_next  = '0;
                sak_next   = '0;
                for (int j = 0; j < UID_BYTES; j++)
                begin
                    uid_next[j] = '0;
                end
                phase_next = PH_ATQA;
                res_hit    = 1'b1;
                txd_next   = {48'b0, WUPA_CODE};
                txl_next   = LEN_WUPA;
                sf_next    = 1'b1;
            end
            OP_RX_FAIL:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    res_hit    = 1'b1;
                    kind_next  = KIND_DONE;
                    st_next    = ST_RX_FAIL;
                    phase_next = PH_IDLE;
                end
            end
            OP_RX_OK:
            begin
                case (phase_reg)
                    PH_ATQA:
                    begin
                        res_hit = 1'b1;
                        if (len_reg != LEN_ATQA)
                        begin
                            kind_next  = KIND_DONE;
                            st_next    = ST_PROTO;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            atqa_next = {b[1], b[0]};
                            if ((b[0] & ATQA_AC_MASK) == 8'h00)
                            begin
                                kind_next  = KIND_DONE;
                                st_next    = ST_PROTO;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                level_next = '0;
                                phase_next = PH_SDD;
                                txd_next   = {40'b0, NVB_SDD, SEL_BASE};
                                txl_next   = LEN_SDD;
                            end
                        end
                    end
                    PH_SDD:
                    begin
                        res_hit = 1'b1;
                        if ((len_reg != LEN_UID) || ((b[0] ^ b[1] ^ b[2] ^ b[3]) != b[4]))
                        begin
                            kind_next  = KIND_DONE;
                            st_next    = ST_PROTO;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            tag_next = skip;
                            // place the new uid bytes after those already held
                            for (int j = 0; j < UID_BYTES; j++)
                            begin
                                if ((5'(j) >= {1'b0, cnt_reg}) &&
                                    ((5'(j) - {1'b0, cnt_reg}) < (skip ? 5'd3 : 5'd4)))
                                begin
                                    uid_next[j] =
                                        b[3'(5'(j) - {1'b0, cnt_reg}) + {2'b0, skip}];
                                end
                            end
                            cnt_next   = (cnt_sum > 5'(UID_BYTES)) ? 4'(UID_BYTES)
                                                                   : cnt_sum[3:0];
                            phase_next = PH_SAK;
                            txd_next   = {rx_reg, NVB_SEL, sel_code};
                            txl_next   = LEN_SEL;
                            crc_next   = 1'b1;
                        end
                    end
                    PH_SAK:
                    begin
                        res_hit = 1'b1;
                        if (len_reg != LEN_SAK)
                        begin
                            kind_next  = KIND_DONE;
                            st_next    = ST_PROTO;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            sak_next = b[0];
                            if ((b[0][2] != tag_reg) || (b[0][2] && (level_reg >= 2'd2)))
                            begin
                                kind_next  = KIND_DONE;
                                st_next    = ST_PROTO;
                                phase_next = PH_IDLE;
                            end
                            else if (b[0][2])
                            begin
                                level_next = level_reg + 2'd1;
                                phase_next = PH_SDD;
                                txd_next   = {40'b0, NVB_SDD,
                                              SEL_BASE + {5'b0, level_next, 1'b0}};
                                txl_next   = LEN_SDD;
                            end
                            else
                            begin
                                kind_next  = KIND_DONE;
                                st_next    = ST_OK;
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // state update as the item leaves stage one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            level_reg <= '0;
            tag_reg   <= 1'b0;
            cnt_reg   <= '0;
            atqa_reg  <= '0;
            sak_reg   <= '0;
            for (int j = 0; j < UID_BYTES; j++)
            begin
                uid_reg[j] <= '0;
            end
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            level_reg <= level_next;
            tag_reg   <= tag_next;
            cnt_reg   <= cnt_next;
            atqa_reg  <= atqa_next;
            sak_reg   <= sak_next;
            for (int j = 0; j < UID_BYTES; j++)
            begin
                uid_reg[j] <= uid_next[j];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance && res_hit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_hit)
        begin
            kind_reg <= kind_next;
            txd_reg  <= txd_next;
            txl_reg  <= txl_next;
            sf_reg   <= sf_next;
            crc_reg  <= crc_next;
            st_reg   <= st_next;
        end
    end

    assign out_valid         = out_vld_reg;
    assign result_kind       = kind_reg;
    assign tx_data           = txd_reg;
    assign tx_length         = txl_reg;
    assign tx_short_frame    = sf_reg;
    assign tx_crc_on         = crc_reg;
    assign finish_status     = st_reg;
    assign answer_to_request = atqa_reg;
    assign select_ack        = sak_reg;
    assign uid_length        = cnt_reg;

    // uid bytes onto the two output words, unused slots read zero
    for (genvar g = 0; g < 10; g++)
    begin : g_uid
        if (g < UID_BYTES)
        begin : g_used
            if (g < 8)
            begin : g_lo
                assign uid_low[8*g +: 8] = uid_reg[g];
            end
            else
            begin : g_hi
                assign uid_high[8*(g-8) +: 8] = uid_reg[g];
            end
        end
        else
        begin : g_none
            if (g < 8)
            begin : g_lo
                assign uid_low[8*g +: 8] = 8'h00;
            end
            else
            begin : g_hi
                assign uid_high[8*(g-8) +: 8] = 8'h00;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/isoac_chk.sv
`default_nettype none
module isoac_chk
    import isoac_pkg::*;
#(
    parameter int UID_BYTES = 10
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        result_kind,
    input wire logic [55:0] tx_data,
    input wire logic [2:0]  tx_length,
    input wire logic        tx_short_frame,
    input wire logic        tx_crc_on,
    input wire logic [15:0] answer_to_request,
    input wire logic [3:0]  uid_length
);

    // a stalled result keeps its frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tx_data) && $stable(result_kind))
        else $error("stalled result changed");

    // a finish result carries no frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_DONE) |->
            (tx_length == 3'd0) && !tx_short_frame && !tx_crc_on && (tx_data == 56'd0))
        else $error("finish result with frame content");

    // wupa comes with a cleared uid and atqa
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_TX) && tx_short_frame |->
            (tx_length == LEN_WUPA) && (tx_data == {48'b0, WUPA_CODE}) &&
            (uid_length == 4'd0) && (answer_to_request == 16'd0))
        else $error("bad wupa result");

    // crc framing only on select frames
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_TX) && tx_crc_on |->
            (tx_length == LEN_SEL) && (tx_data[15:8] == NVB_SEL))
        else $error("crc on a non-select frame");

    // uid count stays within the store
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (uid_length <= 4'(UID_BYTES)))
        else $error("uid count beyond store");

endmodule

bind iso14443a_anticollision_sequencer isoac_chk #(.UID_BYTES(UID_BYTES)) u_isoac_chk (.*);
`default_nettype wire
